/* rtl/core/chained_hash_table_top_defines.svh */
// Assertion macros for the hash table block
`ifndef CHAINED_HASH_TABLE_TOP_DEFINES_SVH
`define CHAINED_HASH_TABLE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Consequent in the same cycle
`define CHT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash table assertion failed");
// Consequent in the next cycle
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash table assertion failed");
`else
`define CHT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/cht_pkg.sv */
package cht_pkg;

  localparam int BUCKETS      = 64;
  localparam int POOL_ENTRIES = 256;
  localparam int KEY_BITS     = 16;

  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int PTR_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int USED_W = $clog2(POOL_ENTRIES + 1);
  localparam int CNT_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int BC_W   = 7;
  localparam int ADDR_W = 7;
  localparam int PRB_W  = 9;

  localparam logic [BC_W-1:0] BC_RESET = 7'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RDB,
    ST_BKT,
    ST_LINK,
    ST_RDN,
    ST_CMP,
    ST_FIN
  } state_t;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic empty_srch;
    logic chain_start;
    logic set_full;
    logic ins_node;
    logic link;
    logic probe_cmp;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic is_search;
    logic head_valid;
    logic pool_full;
    logic hit;
    logic chain_end;
    logic out_free;
  } status_t;

endpackage

/* rtl/core/cht_if.sv */
interface cht_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [cht_pkg::KEY_BITS-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface cht_out_if;
  logic                       valid;
  logic                       ready;
  logic [cht_pkg::ADDR_W-1:0] bucket_addr;
  logic                       found;
  logic [cht_pkg::PRB_W-1:0]  probes;
  logic                       pool_full;

  modport source (output valid, output bucket_addr, output found, output probes,
                  output pool_full, input ready);
  modport sink   (input valid, input bucket_addr, input found, input probes,
                  input pool_full, output ready);
endinterface

/* rtl/core/cht_ram.sv */
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/cht_ctrl.sv */
module cht_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cht_pkg::status_t status,
  output cht_pkg::cmd_t    cmd
);

  cht_pkg::state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cht_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequence one item through hash, bucket lookup, and then an insert or a chain walk
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      cht_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = cht_pkg::ST_DIV;
        end
      end
      cht_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = cht_pkg::ST_RDB;
        end
      end
      cht_pkg::ST_RDB: begin
        state_nxt = cht_pkg::ST_BKT;
      end
      cht_pkg::ST_BKT: begin
        if (status.is_search) begin
          if (!status.head_valid) begin
            cmd.empty_srch = 1'b1;
            state_nxt      = cht_pkg::ST_FIN;
          end else begin
            cmd.chain_start = 1'b1;
            state_nxt       = cht_pkg::ST_RDN;
          end
        end else if (status.pool_full) begin
          cmd.set_full = 1'b1;
          state_nxt    = cht_pkg::ST_FIN;
        end else begin
          cmd.ins_node = 1'b1;
          state_nxt    = status.head_valid ? cht_pkg::ST_LINK : cht_pkg::ST_FIN;
        end
      end
      cht_pkg::ST_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = cht_pkg::ST_FIN;
      end
      cht_pkg::ST_RDN: begin
        state_nxt = cht_pkg::ST_CMP;
      end
      cht_pkg::ST_CMP: begin
        cmd.probe_cmp = 1'b1;
        state_nxt     = (status.hit || status.chain_end) ? cht_pkg::ST_FIN
                                                         : cht_pkg::ST_RDN;
      end
      cht_pkg::ST_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = cht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cht_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/cht_dp.sv */
module cht_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cht_pkg::BC_W-1:0]      cfg_wdata,
  input  logic                          in_req_type,
  input  logic [cht_pkg::KEY_BITS-1:0]  in_key,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [cht_pkg::ADDR_W-1:0]    out_bucket_addr,
  output logic                          out_found,
  output logic [cht_pkg::PRB_W-1:0]     out_probes,
  output logic                          out_pool_full,
  input  cht_pkg::cmd_t                 cmd,
  output cht_pkg::status_t              status
);

  localparam int BKT_W  = cht_pkg::BKT_W;
  localparam int PTR_W  = cht_pkg::PTR_W;
  localparam int BC_W   = cht_pkg::BC_W;
  localparam int PRB_W  = cht_pkg::PRB_W;
  localparam int USED_W = cht_pkg::USED_W;
  localparam int KEY_W  = cht_pkg::KEY_BITS;

  logic [BC_W-1:0]          bc_r;
  logic [KEY_W-1:0]         key_r, sh_r;
  logic                     req_r;
  logic [BC_W-1:0]          rem_r;
  logic [cht_pkg::CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0]         cur_r;
  logic [PRB_W-1:0]         probes_r;
  logic                     found_r, full_r;
  logic [USED_W-1:0]        used_r;
  logic [cht_pkg::BUCKETS-1:0] hv_r;

  logic                          out_valid_r;
  logic [cht_pkg::ADDR_W-1:0]    out_addr_r;
  logic                          out_found_r, out_full_r;
  logic [PRB_W-1:0]              out_probes_r;

  logic [BC_W-1:0]  modv;
  logic [BC_W:0]    rem2;
  logic [BKT_W-1:0] bkt;
  logic [PRB_W-1:0] probes_inc;
  logic             hv_cur;

  logic [PTR_W-1:0] head_rd, tail_rd;
  logic [KEY_W-1:0] key_rd;
  logic [PTR_W:0]   nxt_rd;
  logic             next_we;
  logic [PTR_W-1:0] next_waddr;
  logic [PTR_W:0]   next_wdata;
  logic [PTR_W-1:0] new_node;

  // clamp the modulus to 1..BUCKETS
  always_comb begin
    if (bc_r == '0) begin
      modv = BC_W'(1);
    end else if ({1'b0, bc_r} > (BC_W + 1)'(cht_pkg::BUCKETS)) begin
      modv = BC_W'(cht_pkg::BUCKETS);
    end else begin
      modv = bc_r;
    end
  end

  assign rem2       = {rem_r, sh_r[KEY_W-1]};
  assign bkt        = rem_r[BKT_W-1:0];
  assign hv_cur     = hv_r[bkt];
  assign probes_inc = probes_r + PRB_W'(1);
  assign new_node   = used_r[PTR_W-1:0];

  // register the modulus
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r <= cht_pkg::BC_RESET;
    end else if (cfg_we) begin
      bc_r <= cfg_wdata;
    end
  end

  // capture the item and run the restoring remainder, one key bit a beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r    <= in_key;
      sh_r     <= in_key;
      req_r    <= in_req_type;
      rem_r    <= '0;
      cnt_r    <= '0;
      probes_r <= '0;
      found_r  <= 1'b0;
      full_r   <= 1'b0;
    end else begin
      if (cmd.div_step) begin
        sh_r  <= sh_r << 1;
        cnt_r <= cnt_r + cht_pkg::CNT_W'(1);
        if (rem2 >= {1'b0, modv}) begin
          rem_r <= BC_W'(rem2 - {1'b0, modv});
        end else begin
          rem_r <= rem2[BC_W-1:0];
        end
      end
      if (cmd.empty_srch) begin
        probes_r <= PRB_W'(1);
      end
      if (cmd.set_full) begin
        full_r <= 1'b1;
      end
      if (cmd.chain_start) begin
        cur_r <= head_rd;
      end
      if (cmd.ins_node) begin
        cur_r <= tail_rd;
      end
      if (cmd.probe_cmp) begin
        probes_r <= probes_inc;
        found_r  <= status.hit;
        cur_r    <= nxt_rd[PTR_W-1:0];
      end
    end
  end

  // track pool use and bucket head valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      hv_r   <= '0;
    end else begin
      if ((cmd.ins_node && !hv_cur) || cmd.link) begin
        used_r <= used_r + USED_W'(1);
      end
      if (cmd.ins_node) begin
        hv_r[bkt] <= 1'b1;
      end
    end
  end

  // drive the next-link store: new node first, then the old tail
  always_comb begin
    next_we    = cmd.ins_node || cmd.link;
    next_waddr = cmd.link ? cur_r : new_node;
    next_wdata = cmd.link ? {1'b1, new_node} : '0;
  end

  cht_ram #(.WIDTH(PTR_W), .DEPTH(cht_pkg::BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (cmd.ins_node && !hv_cur),
    .waddr (bkt),
    .wdata (new_node),
    .raddr (bkt),
    .rdata (head_rd)
  );

  cht_ram #(.WIDTH(PTR_W), .DEPTH(cht_pkg::BUCKETS)) u_tail_ram (
    .clk   (clk),
    .we    (cmd.ins_node),
    .waddr (bkt),
    .wdata (new_node),
    .raddr (bkt),
    .rdata (tail_rd)
  );

  cht_ram #(.WIDTH(KEY_W), .DEPTH(cht_pkg::POOL_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (cmd.ins_node),
    .waddr (new_node),
    .wdata (key_r),
    .raddr (cur_r),
    .rdata (key_rd)
  );

  cht_ram #(.WIDTH(PTR_W + 1), .DEPTH(cht_pkg::POOL_ENTRIES)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (cur_r),
    .rdata (nxt_rd)
  );

  // hold the result until the sink takes the beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_addr_r   <= cht_pkg::ADDR_W'({1'b0, rem_r} + (BC_W + 1)'(1));
      out_found_r  <= found_r;
      out_probes_r <= probes_r;
      out_full_r   <= full_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bucket_addr = out_addr_r;
  assign out_found       = out_found_r;
  assign out_probes      = out_probes_r;
  assign out_pool_full   = out_full_r;

  // report status to the controller
  always_comb begin
    status.div_last   = (cnt_r == cht_pkg::CNT_W'(KEY_W - 1));
    status.is_search  = (req_r == cht_pkg::REQ_SEARCH);
    status.head_valid = hv_cur;
    status.pool_full  = (used_r == USED_W'(cht_pkg::POOL_ENTRIES));
    status.hit        = (key_rd == key_r);
    status.chain_end  = !nxt_rd[PTR_W] ||
                        ({1'b0, probes_inc} >= (PRB_W + 1)'(cht_pkg::POOL_ENTRIES));
    status.out_free   = !out_valid_r || out_ready;
  end

endmodule

/* rtl/core/chained_hash_table_top.sv */
// Chained hash table: each input beat inserts or searches a key; one result beat
// follows per item. The bucket is key mod bucket_count (clamped to 1..64), reported
// plus one. Items are handled one at a time. An item is accepted, then runs a
// bit-serial remainder one key bit per step, reads and tests the bucket, links
// behind an old tail when an insert finds a non-empty bucket, reads and compares
// one node per probe when a search walks a non-empty chain, and posts the result.
// A result beat still held by the sink stalls the post step. The registered read
// of the node RAMs puts a read state ahead of each probe's compare. No clearing
// pass is needed after reset.
`include "chained_hash_table_top_defines.svh"

module chained_hash_table_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [cht_pkg::BC_W-1:0] cfg_wdata,
  cht_in_if.sink                   in_ch,
  cht_out_if.source                out_ch
);

  cht_pkg::cmd_t    cmd;
  cht_pkg::status_t status;
  logic             in_ready;

  assign in_ch.ready = in_ready;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cht_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_ch.req_type),
    .in_key          (in_ch.key),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_bucket_addr (out_ch.bucket_addr),
    .out_found       (out_ch.found),
    .out_probes      (out_ch.probes),
    .out_pool_full   (out_ch.pool_full),
    .cmd             (cmd),
    .status          (status)
  );

  // busy right after an accepted beat
  `CHT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ready, !in_ready)
  // a hit has examined at least one entry
  `CHT_ASSERT_SAME(a_hit_probes, clk, rst_n, out_ch.valid && out_ch.found,
                   out_ch.probes != '0)
  // a dropped insert reports no search outcome
  `CHT_ASSERT_SAME(a_full_clean, clk, rst_n, out_ch.valid && out_ch.pool_full,
                   !out_ch.found && out_ch.probes == '0)
  // only one command fires per cycle
  `CHT_ASSERT_SAME(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule

/* tb/cht_tb_if.sv */
`timescale 1ns / 100ps

// Testbench copies are not needed: the RTL interfaces cht_in_if / cht_out_if are used.
// This file holds a small helper package of testbench types.
package cht_tb_pkg;
  typedef struct packed {
    logic [cht_pkg::ADDR_W-1:0] bucket_addr;
    logic                       found;
    logic [cht_pkg::PRB_W-1:0]  probes;
    logic                       pool_full;
  } lookup_res_t;
endpackage

/* tb/tb_chained_hash_table_top.sv */
`timescale 1ns / 100ps

module tb_chained_hash_table_top;

  // Shadow copy of the table and queue of expected results
  class hash_scoreboard;
    int unsigned bucket_cnt;
    bit          head_ok[cht_pkg::BUCKETS];
    int unsigned head_idx[cht_pkg::BUCKETS];
    int unsigned tail_idx[cht_pkg::BUCKETS];
    logic [cht_pkg::KEY_BITS-1:0] key_at[cht_pkg::POOL_ENTRIES];
    int unsigned link_at[cht_pkg::POOL_ENTRIES];
    bit          link_ok[cht_pkg::POOL_ENTRIES];
    int unsigned used;
    cht_tb_pkg::lookup_res_t pending[$];
    int unsigned errors, hits, fulls, results;

    function new();
      bucket_cnt = cht_pkg::BC_RESET;
      foreach (head_ok[i]) head_ok[i] = 0;
      foreach (link_ok[i]) link_ok[i] = 0;
      used = 0;
      errors = 0; hits = 0; fulls = 0; results = 0;
    endfunction

    // Work out the result of one accepted beat and update the shadow table
    function void note_request(logic is_search, logic [cht_pkg::KEY_BITS-1:0] k);
      int unsigned m, b, cur, steps;
      cht_tb_pkg::lookup_res_t r;
      m = (bucket_cnt == 0) ? 1 :
          (bucket_cnt > cht_pkg::BUCKETS ? cht_pkg::BUCKETS : bucket_cnt);
      b = k % m;
      r = '0;
      if (is_search == cht_pkg::REQ_INSERT) begin
        if (used >= cht_pkg::POOL_ENTRIES) begin
          r.pool_full = 1'b1;
        end else begin
          key_at[used] = k;
          link_ok[used] = 0;
          if (head_ok[b]) begin
            link_at[tail_idx[b]] = used;
            link_ok[tail_idx[b]] = 1;
          end else begin
            head_idx[b] = used;
            head_ok[b] = 1;
          end
          tail_idx[b] = used;
          used++;
        end
      end else if (!head_ok[b]) begin
        r.probes = 1;
      end else begin
        cur = head_idx[b];
        steps = 0;
        forever begin
          steps++;
          if (key_at[cur] == k) begin
            r.found = 1'b1;
            break;
          end
          if (!link_ok[cur] || steps >= cht_pkg::POOL_ENTRIES) break;
          cur = link_at[cur];
        end
        r.probes = steps[cht_pkg::PRB_W-1:0];
      end
      r.bucket_addr = cht_pkg::ADDR_W'(b + 1);
      pending.push_back(r);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(cht_tb_pkg::lookup_res_t got);
      cht_tb_pkg::lookup_res_t exp_r;
      results++;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.found) hits++;
      if (got.pool_full) fulls++;
      if (got.bucket_addr !== exp_r.bucket_addr) begin
        $error("bucket_addr exp %0d got %0d", exp_r.bucket_addr, got.bucket_addr);
        errors++;
      end
      if (got.found !== exp_r.found) begin
        $error("found exp %0d got %0d", exp_r.found, got.found);
        errors++;
      end
      if (got.probes !== exp_r.probes) begin
        $error("probes exp %0d got %0d", exp_r.probes, got.probes);
        errors++;
      end
      if (got.pool_full !== exp_r.pool_full) begin
        $error("pool_full exp %0d got %0d", exp_r.pool_full, got.pool_full);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [cht_pkg::BC_W-1:0] cfg_wdata = '0;

  cht_in_if  in_ch ();
  cht_out_if out_ch ();

  hash_scoreboard sb = new();
  int unsigned items_sent = 0;
  bit stress_drain = 0;

  chained_hash_table_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = cht_pkg::REQ_INSERT;
    in_ch.key = '0;
    out_ch.ready = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one beat and hold it until accepted; valid stays up for a follow-on beat
  task automatic send_req(logic is_search, logic [cht_pkg::KEY_BITS-1:0] k,
                          bit idle_ok = 1);
    int unsigned g;
    g = idle_ok ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= is_search;
    in_ch.key <= k;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(is_search, k);
    items_sent++;
  endtask

  // Write the modulus once the block is idle
  task automatic set_buckets(logic [cht_pkg::BC_W-1:0] v);
    in_ch.valid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.bucket_cnt = v;
  endtask

  // Result side: random stalls, now and then a long one, checked at the handshake
  initial begin
    int unsigned stall;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.bucket_addr, out_ch.found, out_ch.probes, out_ch.pool_full});
      if (stall > 0) stall--;
      else if ($urandom_range(0, 99) < 2) stall = $urandom_range(10, 40);
      out_ch.ready <= stress_drain || (stall == 0 && $urandom_range(0, 99) < 70);
    end
  end

  // Search key: half the time one already stored, otherwise random
  function automatic logic [cht_pkg::KEY_BITS-1:0] pick_key(int unsigned span);
    if (sb.used > 0 && $urandom_range(0, 1))
      return sb.key_at[$urandom_range(0, (sb.used > cht_pkg::POOL_ENTRIES ?
                                          cht_pkg::POOL_ENTRIES : sb.used) - 1)];
    return cht_pkg::KEY_BITS'($urandom_range(0, span));
  endfunction

  initial begin
    logic [cht_pkg::BC_W-1:0] settings[6];
    int unsigned n;
    settings = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd13, 7'd7};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty buckets, key extremes, key 0, duplicates, chain misses
    send_req(cht_pkg::REQ_SEARCH, 16'h0000);
    send_req(cht_pkg::REQ_SEARCH, 16'hFFFF);
    send_req(cht_pkg::REQ_INSERT, 16'h0000);
    send_req(cht_pkg::REQ_SEARCH, 16'h0000);
    send_req(cht_pkg::REQ_INSERT, 16'hFFFF);
    send_req(cht_pkg::REQ_INSERT, 16'h0005);
    send_req(cht_pkg::REQ_INSERT, 16'h0005);
    send_req(cht_pkg::REQ_INSERT, 16'hAAAA);
    send_req(cht_pkg::REQ_INSERT, 16'h5555);
    send_req(cht_pkg::REQ_SEARCH, 16'h0005);
    send_req(cht_pkg::REQ_SEARCH, 16'h000A);
    send_req(cht_pkg::REQ_SEARCH, 16'hFFFF);
    send_req(cht_pkg::REQ_SEARCH, 16'h5555);
    send_req(cht_pkg::REQ_SEARCH, 16'h0004);

    // Random phases over several moduli; stored chains stay put across changes
    for (int ph = 0; ph < 6; ph++) begin
      set_buckets(settings[ph]);
      n = (ph == 5) ? 400 : 150;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 99) < 45)
          send_req(cht_pkg::REQ_INSERT, cht_pkg::KEY_BITS'($urandom_range(0, 65535)),
                   i % 40 >= 10);
        else
          send_req(cht_pkg::REQ_SEARCH, pick_key(65535), i % 40 >= 10);
      end
    end

    // Pool is now exhausted: a few dropped inserts, then long chain walks
    send_req(cht_pkg::REQ_INSERT, 16'h1234);
    send_req(cht_pkg::REQ_INSERT, 16'h0000);
    set_buckets(7'd1);
    send_req(cht_pkg::REQ_SEARCH, 16'hBEEF);
    send_req(cht_pkg::REQ_SEARCH, sb.key_at[cht_pkg::POOL_ENTRIES-1]);
    in_ch.valid <= 1'b0;

    stress_drain = 1;
    wait (sb.pending.size() == 0);
    repeat (600) @(posedge clk);
    $display("sent %0d requests, checked %0d results (%0d hits, %0d pool-full drops)",
             items_sent, sb.results, sb.hits, sb.fulls);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end
endmodule

/* chained_hash_table_top.f */
+incdir+rtl/core
rtl/core/cht_pkg.sv
rtl/core/cht_if.sv
rtl/core/cht_ram.sv
rtl/core/cht_ctrl.sv
rtl/core/cht_dp.sv
rtl/core/chained_hash_table_top.sv
tb/cht_tb_if.sv
tb/tb_chained_hash_table_top.sv
